[rtl/core/smbc_pkg.sv]
// shared widths, register codes, band word layout and lookup tables for the compressor
package smbc_pkg;

    localparam int MAX_BANDS   = 4;
    localparam int BAND_W      = $clog2(MAX_BANDS);
    localparam int CNT_W       = 3;
    localparam int SAMPLE_BITS = 24;
    localparam int ENV_W       = SAMPLE_BITS;
    localparam int GAIN_W      = 20;
    localparam int MEM_W       = ENV_W + GAIN_W;
    localparam int SUM_W       = GAIN_W + BAND_W + 1;
    localparam int DB_W        = 13;
    localparam int MDB_W       = 12;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;

    // long division in the knee blend
    localparam int QUO_W = 10;
    localparam int DEN_W = 10;
    localparam int NUM_W = QUO_W + DEN_W + 1;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);

    localparam logic [4:0] ENV_REF  = 5'(SAMPLE_BITS - 1);
    localparam logic [4:0] GAIN_REF = 5'd16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_SEL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_WORD0 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_WORD1 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_WORD2 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_WORD3 = 3'd5;

    // band word field positions
    localparam int THR_LSB = 0;
    localparam int KNEE_LSB = 12;
    localparam int IR_LSB  = 22;
    localparam int ATK_LSB = 34;
    localparam int REL_LSB = 46;
    localparam int MK_LSB  = 58;

    localparam logic [11:0] LOG2_TAB [32] = '{
        12'd0,    12'd182,  12'd358,  12'd530,  12'd696,  12'd858,  12'd1016, 12'd1169,
        12'd1319, 12'd1465, 12'd1607, 12'd1746, 12'd1882, 12'd2015, 12'd2145, 12'd2272,
        12'd2396, 12'd2518, 12'd2637, 12'd2754, 12'd2869, 12'd2982, 12'd3092, 12'd3200,
        12'd3307, 12'd3412, 12'd3514, 12'd3615, 12'd3715, 12'd3812, 12'd3908, 12'd4003
    };

    localparam logic [16:0] EXP2_TAB [32] = '{
        17'd65536,  17'd66971,  17'd68438,  17'd69937,
        17'd71468,  17'd73033,  17'd74632,  17'd76267,
        17'd77936,  17'd79642,  17'd81386,  17'd83169,
        17'd84990,  17'd86851,  17'd88752,  17'd90696,
        17'd92682,  17'd94711,  17'd96785,  17'd98905,
        17'd101070, 17'd103283, 17'd105545, 17'd107856,
        17'd110218, 17'd112631, 17'd115098, 17'd117618,
        17'd120194, 17'd122825, 17'd125515, 17'd128263
    };

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_stat_t;

endpackage

[rtl/core/smbc_in_if.sv]
// input channel: audio and key samples
interface smbc_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [smbc_pkg::SAMPLE_BITS-1:0]    audio_sample;
    logic signed [smbc_pkg::SAMPLE_BITS-1:0]    key_sample;

    modport source (output valid, output audio_sample, output key_sample, input ready);
    modport sink   (input valid, input audio_sample, input key_sample, output ready);
endinterface

[rtl/core/smbc_out_if.sv]
// output channel: gain-controlled sample and mean gain in db
interface smbc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [smbc_pkg::SAMPLE_BITS-1:0] out_sample;
    logic signed [smbc_pkg::MDB_W-1:0]       mean_gain_db;

    modport source (output valid, output out_sample, output mean_gain_db, input ready);
    modport sink   (input valid, input out_sample, input mean_gain_db, output ready);
endinterface

[rtl/core/smbc_div.sv]
// restoring divider, one quotient bit per cycle, for the knee blend
module smbc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [smbc_pkg::NUM_W-1:0]    num,
    input  logic [smbc_pkg::DEN_W-1:0]    den,
    output smbc_pkg::div_stat_t           stat
);

    localparam int CW = $clog2(smbc_pkg::QUO_W + 1);
    localparam int RW = smbc_pkg::NUM_W - smbc_pkg::QUO_W;

    logic [RW-1:0]                rem_reg;
    logic [smbc_pkg::QUO_W-1:0]   sh_reg;
    logic [CW-1:0]                cnt_reg;
    logic                         done_reg;
    logic [smbc_pkg::DEN_W-1:0]   den_reg;

    logic [RW:0]                  trial;
    logic                         fits;
    logic [RW:0]                  diff;

    assign trial = {rem_reg, sh_reg[smbc_pkg::QUO_W-1]};
    assign fits  = trial >= {{(RW + 1 - smbc_pkg::DEN_W){1'b0}}, den_reg};
    assign diff  = trial - {{(RW + 1 - smbc_pkg::DEN_W){1'b0}}, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            sh_reg   <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= num[smbc_pkg::NUM_W-1:smbc_pkg::QUO_W];
                sh_reg  <= num[smbc_pkg::QUO_W-1:0];
                den_reg <= den;
                cnt_reg <= CW'(smbc_pkg::QUO_W);
            end
            else if (cnt_reg != '0)
            begin
                // remainder stays below the divisor
                rem_reg <= fits ? diff[RW-1:0] : trial[RW-1:0];
                sh_reg  <= {sh_reg[smbc_pkg::QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.quo  = sh_reg;

`ifndef NO_ASSERTIONS
    a_done_after_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0)
        else $error("divider done while still counting");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> cnt_reg == '0)
        else $error("divider restarted while busy");
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == CW'(smbc_pkg::QUO_W))
        else $error("divider count not loaded");
`endif

endmodule

[rtl/core/smbc_db.sv]
// linear to db conversion, 1/16 db units, relative to 2^ref_exp
module smbc_db
(
    input  logic [smbc_pkg::ENV_W-1:0]      v,
    input  logic [4:0]                      ref_exp,
    output logic signed [smbc_pkg::DB_W-1:0] db
);

    logic [4:0]                   p;
    logic [smbc_pkg::ENV_W-1:0]   vn;
    logic [4:0]                   idx;
    logic signed [5:0]            e;
    logic signed [17:0]           l;
    logic signed [33:0]           prod;
    logic [33:0]                  pm;
    logic [33:0]                  q;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < smbc_pkg::ENV_W; i++)
        begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        // normalize so the leading one sits at the top
        vn   = v << (5'(smbc_pkg::ENV_W - 1) - p);
        idx  = vn[smbc_pkg::ENV_W-2:smbc_pkg::ENV_W-6];
        e    = $signed({1'b0, p}) - $signed({1'b0, ref_exp});
        l    = $signed({e, 12'b0}) + $signed({6'b0, smbc_pkg::LOG2_TAB[idx]});
        prod = l * 34'sd24660;
        pm   = prod[33] ? 34'(-prod) : 34'(prod);
        q    = (pm + 34'd524288) >> 20;
        db   = prod[33] ? -$signed({1'b0, q[11:0]}) : $signed({1'b0, q[11:0]});
    end

endmodule

[rtl/core/sidechain_multiband_compressor.sv]
// top level: band sequencer around the envelope/gain state memory
//
//  channel   dir  handshake        payload
//  din       in   valid / ready    audio_sample, key_sample
//  dout      out  valid / ready    out_sample, mean_gain_db
//  cfg       in   cfg_en           cfg_addr, cfg_data
//
// each item steps through ST_RD to ST_SM2 for each of its n active bands, waiting in ST_DIV
// for each band whose level falls inside its knee (the serial divider of the blend)
// each band does a read, modify and write of its state memory entry
// reset clears config; memory entries read as zero envelope and unity gain until written
// a new transaction is taken only in idle; a stalled output holds the finished result
module sidechain_multiband_compressor
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [smbc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [smbc_pkg::CFG_DATA_W-1:0]     cfg_data,
    smbc_in_if.sink                             din,
    smbc_out_if.source                          dout
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_ENV, ST_DB, ST_ABV, ST_KNEE, ST_DIV,
        ST_GAIN, ST_LIN, ST_SM1, ST_SM2, ST_MEAN, ST_FIN, ST_OUT
    } state_t;

    localparam int SB = smbc_pkg::SAMPLE_BITS;
    localparam int BW = smbc_pkg::BAND_W;
    localparam int GW = smbc_pkg::GAIN_W;
    localparam int EW = smbc_pkg::ENV_W;

    state_t state_reg;

    // configuration
    logic [smbc_pkg::CNT_W-1:0]       band_count_reg;
    logic                             key_sel_reg;
    logic [smbc_pkg::CFG_DATA_W-1:0]  band_word_reg [smbc_pkg::MAX_BANDS];

    // item and band working registers
    logic signed [SB-1:0]             sample_reg;
    logic [EW-1:0]                    mag_reg;
    logic [smbc_pkg::CNT_W-1:0]       n_reg;
    logic [BW-1:0]                    band_reg;
    logic [smbc_pkg::SUM_W-1:0]       sum_reg;
    logic [EW-1:0]                    env_reg;
    logic [GW-1:0]                    gain_old_reg;
    logic signed [smbc_pkg::DB_W-1:0] x_reg;
    logic signed [15:0]               above_reg;
    logic signed [15:0]               c_reg;
    logic                             neg_reg;
    logic [17:0]                      l_reg;
    logic [GW-1:0]                    lin_reg;
    logic [31:0]                      sm_p1_reg;
    logic [GW-1:0]                    mean_reg;
    logic signed [44:0]               yprod_reg;
    logic signed [smbc_pkg::MDB_W-1:0] mdb_reg;

    logic                             out_valid_reg;
    logic signed [SB-1:0]             out_sample_reg;
    logic signed [smbc_pkg::MDB_W-1:0] out_mdb_reg;

    // state memory
    logic [smbc_pkg::MEM_W-1:0]       mem [smbc_pkg::MAX_BANDS];
    logic [smbc_pkg::MEM_W-1:0]       rdata_reg;
    logic [smbc_pkg::MAX_BANDS-1:0]   valid_reg;
    logic                             rd_valid_reg;

    logic [smbc_pkg::CFG_DATA_W-1:0]  w;
    logic signed [11:0]               thr;
    logic [9:0]                       knee;
    logic [11:0]                      ir;
    logic [11:0]                      atk;
    logic [11:0]                      rel;
    logic [5:0]                       mk;

    assign w    = band_word_reg[band_reg];
    assign thr  = w[smbc_pkg::THR_LSB +: 12];
    assign knee = w[smbc_pkg::KNEE_LSB +: 10];
    assign ir   = w[smbc_pkg::IR_LSB +: 12];
    assign atk  = w[smbc_pkg::ATK_LSB +: 12];
    assign rel  = w[smbc_pkg::REL_LSB +: 12];
    assign mk   = w[smbc_pkg::MK_LSB +: 6];

    // input key magnitude
    logic signed [SB-1:0]  key_sel;
    logic signed [SB:0]    key_neg;
    logic [EW-1:0]         key_mag;
    logic [smbc_pkg::CNT_W-1:0] n_eff;

    always_comb
    begin
        key_sel = key_sel_reg ? din.audio_sample : din.key_sample;
        key_neg = -$signed({key_sel[SB-1], key_sel});
        key_mag = key_sel[SB-1] ? key_neg[EW-1:0] : key_sel;
        if (band_count_reg == '0)
        begin
            n_eff = smbc_pkg::CNT_W'(1);
        end
        else if (band_count_reg > smbc_pkg::CNT_W'(smbc_pkg::MAX_BANDS))
        begin
            n_eff = smbc_pkg::CNT_W'(smbc_pkg::MAX_BANDS);
        end
        else
        begin
            n_eff = band_count_reg;
        end
    end

    // envelope update
    logic [EW-1:0]          env_old;
    logic [GW-1:0]          gain_old;
    logic [11:0]            coef;
    logic signed [25:0]     env_diff;
    logic signed [38:0]     env_prod;
    logic [38:0]            env_pm;
    logic [38:0]            env_q;
    logic signed [26:0]     env_step;
    logic signed [27:0]     env_sum;
    logic [EW-1:0]          env_new;

    always_comb
    begin
        env_old  = rd_valid_reg ? rdata_reg[smbc_pkg::MEM_W-1:GW] : '0;
        gain_old = rd_valid_reg ? rdata_reg[GW-1:0] : smbc_pkg::GAIN_UNITY;
        coef     = (mag_reg > env_old) ? atk : rel;
        env_diff = $signed({2'b0, mag_reg}) - $signed({2'b0, env_old});
        env_prod = $signed({1'b0, coef}) * env_diff;
        env_pm   = env_prod[38] ? 39'(-env_prod) : 39'(env_prod);
        env_q    = (env_pm + 39'd2048) >> 12;
        env_step = env_prod[38] ? -$signed({1'b0, env_q[25:0]})
                                : $signed({1'b0, env_q[25:0]});
        env_sum  = $signed({4'b0, env_old}) + $signed({env_step[26], env_step});
        if (env_sum < 0)
        begin
            env_new = '0;
        end
        else if (env_sum > $signed({4'b0, {EW{1'b1}}}))
        begin
            env_new = {EW{1'b1}};
        end
        else
        begin
            env_new = env_sum[EW-1:0];
        end
    end

    // shared db converter: envelope in ST_DB, mean gain in ST_FIN
    logic [EW-1:0]                    db_in;
    logic [4:0]                       db_ref;
    logic signed [smbc_pkg::DB_W-1:0] db_out;

    assign db_in  = (state_reg == ST_FIN) ? {{(EW - GW){1'b0}}, mean_reg} : env_reg;
    assign db_ref = (state_reg == ST_FIN) ? smbc_pkg::GAIN_REF : smbc_pkg::ENV_REF;

    smbc_db u_db
    (
        .v       (db_in),
        .ref_exp (db_ref),
        .db      (db_out)
    );

    // compressed level above threshold
    logic signed [13:0]  x_t;
    logic signed [26:0]  abv_prod;
    logic [26:0]         abv_pm;
    logic [26:0]         abv_q;
    logic signed [15:0]  abv_step;
    logic signed [15:0]  above_new;

    always_comb
    begin
        x_t       = $signed({x_reg[12], x_reg}) - $signed({{2{thr[11]}}, thr});
        abv_prod  = x_t * $signed({1'b0, ir});
        abv_pm    = abv_prod[26] ? 27'(-abv_prod) : 27'(abv_prod);
        abv_q     = (abv_pm + 27'd2048) >> 12;
        abv_step  = abv_prod[26] ? -$signed({1'b0, abv_q[14:0]})
                                 : $signed({1'b0, abv_q[14:0]});
        above_new = $signed({{4{thr[11]}}, thr}) + abv_step;
    end

    // knee region decision and blend product
    logic [9:0]                   half;
    logic signed [15:0]           x16;
    logic signed [15:0]           lo;
    logic signed [15:0]           hi;
    logic                         below;
    logic                         over;
    logic signed [15:0]           ka;
    logic signed [16:0]           kb;
    logic signed [32:0]           kprod;
    logic [32:0]                  kpm;
    logic [smbc_pkg::NUM_W-1:0]   div_num;
    logic                         div_start;
    smbc_pkg::div_stat_t          div_stat;

    always_comb
    begin
        half    = {1'b0, knee[9:1]};
        x16     = $signed({{3{x_reg[12]}}, x_reg});
        lo      = $signed({{4{thr[11]}}, thr}) - $signed({6'b0, half});
        hi      = $signed({{4{thr[11]}}, thr}) + $signed({6'b0, half});
        below   = x16 < lo;
        over    = (x16 > hi) || (knee == '0);
        ka      = x16 - $signed({{4{thr[11]}}, thr}) + $signed({6'b0, half});
        kb      = $signed({above_reg[15], above_reg}) - $signed({x16[15], x16});
        kprod   = ka * kb;
        kpm     = kprod[32] ? 33'(-kprod) : 33'(kprod);
        // within the knee the product stays below 2^20
        div_num = {1'b0, kpm[19:0]} + {11'b0, half};
        div_start = (state_reg == ST_KNEE) && !below && !over;
    end

    smbc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (knee),
        .stat  (div_stat)
    );

    logic signed [15:0] c_blend;

    assign c_blend = neg_reg ? x16 - $signed({6'b0, div_stat.quo})
                             : x16 + $signed({6'b0, div_stat.quo});

    // band gain in db and to linear
    logic signed [16:0]  g_db;
    logic signed [11:0]  g_cl;
    logic signed [26:0]  g_prod;
    logic [26:0]         g_pm;
    logic [26:0]         g_q;
    logic signed [18:0]  g_step;
    logic signed [18:0]  l_new;

    always_comb
    begin
        g_db = $signed({c_reg[15], c_reg}) - $signed({{4{x_reg[12]}}, x_reg})
             + $signed({8'b0, mk, 3'b0});
        if (g_db < -17'sd1536)
        begin
            g_cl = -12'sd1536;
        end
        else if (g_db > 17'sd512)
        begin
            g_cl = 12'sd512;
        end
        else
        begin
            g_cl = g_db[11:0];
        end
        g_prod = g_cl * 27'sd10885;
        g_pm   = g_prod[26] ? 27'(-g_prod) : 27'(g_prod);
        g_q    = (g_pm + 27'd128) >> 8;
        g_step = g_prod[26] ? -$signed({1'b0, g_q[17:0]}) : $signed({1'b0, g_q[17:0]});
        l_new  = g_step + 19'sd131072;
    end

    logic [5:0]   l_exp;
    logic [16:0]  l_val;
    logic [5:0]   l_sh;
    logic [21:0]  l_shl;
    logic [GW-1:0] lin_new;

    always_comb
    begin
        l_exp = l_reg[17:12];
        l_val = smbc_pkg::EXP2_TAB[l_reg[11:7]];
        l_shl = {5'b0, l_val} << l_exp[2:0];
        if (l_exp >= 6'd32)
        begin
            l_sh = l_exp - 6'd32;
            if (l_sh > 6'd5 || l_shl > {2'b0, smbc_pkg::GAIN_MAX})
            begin
                lin_new = smbc_pkg::GAIN_MAX;
            end
            else
            begin
                lin_new = l_shl[GW-1:0];
            end
        end
        else
        begin
            l_sh    = 6'd32 - l_exp;
            lin_new = GW'(l_val >> l_sh);
        end
    end

    // smoothing 0.9 / 0.1
    logic [32:0]   sm_sum;
    logic [32:0]   sm_q;
    logic [GW-1:0] gain_new;

    always_comb
    begin
        sm_sum   = {1'b0, sm_p1_reg} + 33'(lin_reg * 9'd410);
        sm_q     = (sm_sum + 33'd2048) >> 12;
        gain_new = (sm_q > {13'b0, smbc_pkg::GAIN_MAX}) ? smbc_pkg::GAIN_MAX : sm_q[GW-1:0];
    end

    // mean over the active bands
    logic [smbc_pkg::SUM_W-1:0] sum_r1;
    logic [smbc_pkg::SUM_W-1:0] sum_r2;
    logic [47:0]                div3_prod;
    logic [smbc_pkg::SUM_W-1:0] mean_wide;

    always_comb
    begin
        sum_r1    = sum_reg + smbc_pkg::SUM_W'(1);
        sum_r2    = sum_reg + smbc_pkg::SUM_W'(2);
        div3_prod = {25'b0, sum_r1} * 48'd11184811;
        case (n_reg)
            3'd1:    mean_wide = sum_reg;
            3'd2:    mean_wide = sum_r1 >> 1;
            3'd3:    mean_wide = smbc_pkg::SUM_W'(div3_prod >> 25);
            default: mean_wide = sum_r2 >> 2;
        endcase
    end

    // mean gain in db and output rounding
    logic signed [smbc_pkg::MDB_W-1:0] mdb_new;
    logic [44:0]                        y_pm;
    logic [44:0]                        y_q;
    logic signed [SB-1:0]               y_new;

    always_comb
    begin
        if (mean_reg == '0 || db_out < -13'sd1536)
        begin
            mdb_new = -12'sd1536;
        end
        else if (db_out > 13'sd512)
        begin
            mdb_new = 12'sd512;
        end
        else
        begin
            mdb_new = db_out[smbc_pkg::MDB_W-1:0];
        end
        y_pm = yprod_reg[44] ? 45'(-yprod_reg) : 45'(yprod_reg);
        y_q  = (y_pm + 45'd32768) >> 16;
        if (!yprod_reg[44])
        begin
            y_new = (y_q > 45'(2 ** (SB - 1) - 1)) ? $signed({1'b0, {(SB - 1){1'b1}}})
                                                 : $signed(y_q[SB-1:0]);
        end
        else
        begin
            y_new = (y_q >= 45'(2 ** (SB - 1))) ? $signed({1'b1, {(SB - 1){1'b0}}})
                                              : -$signed(y_q[SB-1:0]);
        end
    end

    logic last_band;
    assign last_band = {1'b0, band_reg} == (n_reg - smbc_pkg::CNT_W'(1));

    // state memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SM2)
        begin
            mem[band_reg] <= {env_reg, gain_new};
        end
        if (state_reg == ST_RD)
        begin
            rdata_reg <= mem[band_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            band_count_reg <= smbc_pkg::CNT_W'(1);
            key_sel_reg    <= 1'b0;
            for (int b = 0; b < smbc_pkg::MAX_BANDS; b++)
            begin
                band_word_reg[b] <= '0;
            end
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_mdb_reg    <= '0;
            sample_reg     <= '0;
            mag_reg        <= '0;
            n_reg          <= smbc_pkg::CNT_W'(1);
            band_reg       <= '0;
            sum_reg        <= '0;
            env_reg        <= '0;
            gain_old_reg   <= '0;
            x_reg          <= '0;
            above_reg      <= '0;
            c_reg          <= '0;
            neg_reg        <= 1'b0;
            l_reg          <= '0;
            lin_reg        <= '0;
            sm_p1_reg      <= '0;
            mean_reg       <= '0;
            yprod_reg      <= '0;
            mdb_reg        <= '0;
        end
        else
        begin
            if (cfg_en)
            begin
                unique case (cfg_addr)
                    smbc_pkg::REG_BAND_COUNT: band_count_reg <= cfg_data[smbc_pkg::CNT_W-1:0];
                    smbc_pkg::REG_KEY_SEL:    key_sel_reg    <= cfg_data[0];
                    smbc_pkg::REG_BAND_WORD0: band_word_reg[0] <= cfg_data;
                    smbc_pkg::REG_BAND_WORD1: band_word_reg[1] <= cfg_data;
                    smbc_pkg::REG_BAND_WORD2: band_word_reg[2] <= cfg_data;
                    smbc_pkg::REG_BAND_WORD3: band_word_reg[3] <= cfg_data;
                    default: ;
                endcase
            end

            // in ST_OUT the output register is reloaded below
            if (out_valid_reg && dout.ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (din.valid)
                    begin
                        sample_reg <= din.audio_sample;
                        mag_reg    <= key_mag;
                        n_reg      <= n_eff;
                        band_reg   <= '0;
                        sum_reg    <= '0;
                        state_reg  <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    rd_valid_reg <= valid_reg[band_reg];
                    state_reg    <= ST_ENV;
                end
                ST_ENV:
                begin
                    env_reg      <= env_new;
                    gain_old_reg <= gain_old;
                    state_reg    <= ST_DB;
                end
                ST_DB:
                begin
                    // an empty envelope counts as -200 db
                    x_reg     <= (env_reg == '0) ? -13'sd3200 : db_out;
                    state_reg <= ST_ABV;
                end
                ST_ABV:
                begin
                    above_reg <= above_new;
                    state_reg <= ST_KNEE;
                end
                ST_KNEE:
                begin
                    neg_reg <= kprod[32];
                    if (below)
                    begin
                        c_reg     <= x16;
                        state_reg <= ST_GAIN;
                    end
                    else if (over)
                    begin
                        c_reg     <= above_reg;
                        state_reg <= ST_GAIN;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        c_reg     <= c_blend;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN:
                begin
                    l_reg     <= l_new[17:0];
                    state_reg <= ST_LIN;
                end
                ST_LIN:
                begin
                    lin_reg   <= lin_new;
                    state_reg <= ST_SM1;
                end
                ST_SM1:
                begin
                    sm_p1_reg <= gain_old_reg * 12'd3686;
                    state_reg <= ST_SM2;
                end
                ST_SM2:
                begin
                    valid_reg[band_reg] <= 1'b1;
                    sum_reg <= sum_reg + {{(smbc_pkg::SUM_W - GW){1'b0}}, gain_new};
                    if (last_band)
                    begin
                        state_reg <= ST_MEAN;
                    end
                    else
                    begin
                        band_reg  <= band_reg + BW'(1);
                        state_reg <= ST_RD;
                    end
                end
                ST_MEAN:
                begin
                    mean_reg  <= mean_wide[GW-1:0];
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    yprod_reg <= sample_reg * $signed({1'b0, mean_reg});
                    mdb_reg   <= mdb_new;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || dout.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= y_new;
                        out_mdb_reg    <= mdb_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign din.ready         = (state_reg == ST_IDLE);
    assign dout.valid        = out_valid_reg;
    assign dout.out_sample   = out_sample_reg;
    assign dout.mean_gain_db = out_mdb_reg;

`ifndef NO_ASSERTIONS
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("second transaction taken while busy");
    a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ({1'b0, band_reg} < n_reg))
        else $error("band index beyond active band count");
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");
    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result shown without finishing an item");
`endif

endmodule

[sim/smbc_gain_checker.sv]
// predicts compressor output from observed channel traffic and compares results
module smbc_gain_checker
    import smbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    smbc_in_if                      din,
    smbc_out_if                     dout,
    output int                      errors,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [MDB_W-1:0]       mdb;
    } gain_result_t;

    localparam longint DB_FLOOR    = -1536;
    localparam longint DB_CEIL     = 512;
    localparam longint DB_SILENT   = -3200;
    localparam longint LIN_MAX     = 1048575;

    gain_result_t      expected_q[$];
    logic [CNT_W-1:0]  m_band_count;
    logic              m_key_sel;
    logic [63:0]       m_word [MAX_BANDS];
    longint            m_env [MAX_BANDS];
    longint            m_gain [MAX_BANDS];

    function automatic longint div_round(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // level of v relative to 2^ref in 1/16 db
    function automatic longint level_db(longint v, int ref_bit);
        int     p;
        int     idx;
        longint l;
        p = 63;
        while (p > 0 && !v[p])
            p--;
        if (p >= 5)
            idx = int'((v >> (p - 5)) & 31);
        else
            idx = int'((v << (5 - p)) & 31);
        l = longint'(p) * 4096 + longint'(LOG2_TAB[idx]) - longint'(ref_bit) * 4096;
        return div_round(l * 24660, longint'(1) << 20);
    endfunction

    function automatic longint db_to_linear(longint g);
        longint l;
        longint n;
        longint val;
        l = div_round(g * 10885, 256) + 32 * 4096;
        if (l < 0)
            l = 0;
        n = (l >>> 12) - 32;
        val = longint'(EXP2_TAB[int'((l & 4095) >> 7)]);
        if (n >= 0)
        begin
            if (n > 5)
                return LIN_MAX;
            val = val << n;
        end
        else
        begin
            val = val >> ((-n > 31) ? 31 : -n);
        end
        return val > LIN_MAX ? LIN_MAX : val;
    endfunction

    function automatic longint knee_curve(longint x, logic [63:0] w);
        longint t;
        longint k;
        longint ir;
        longint h;
        longint above;
        t = longint'(signed'(w[THR_LSB +: 12]));
        k = longint'(w[KNEE_LSB +: 10]);
        ir = longint'(w[IR_LSB +: 12]);
        h = k >> 1;
        above = t + div_round((x - t) * ir, 4096);
        if (x < t - h)
            return x;
        if (x > t + h || k == 0)
            return above;
        return x + div_round((x - t + h) * (above - x), k);
    endfunction

    function automatic gain_result_t compress(logic signed [SAMPLE_BITS-1:0] audio,
                                              logic signed [SAMPLE_BITS-1:0] key_in);
        gain_result_t r;
        longint       smp;
        longint       mag;
        longint       n;
        longint       sum;
        longint       mean;
        longint       coef;
        longint       x;
        longint       g;
        logic [63:0]  w;
        smp = longint'(audio);
        mag = m_key_sel ? smp : longint'(key_in);
        if (mag < 0)
            mag = -mag;
        n = (m_band_count == 0) ? 1 : longint'(m_band_count);
        if (n > MAX_BANDS)
            n = MAX_BANDS;
        sum = 0;
        for (int b = 0; b < n; b++)
        begin
            w = m_word[b];
            coef = (mag > m_env[b]) ? longint'(w[ATK_LSB +: 12]) : longint'(w[REL_LSB +: 12]);
            m_env[b] = clip(m_env[b] + div_round(coef * (mag - m_env[b]), 4096),
                            0, (longint'(1) << SAMPLE_BITS) - 1);
            x = (m_env[b] == 0) ? DB_SILENT : level_db(m_env[b], SAMPLE_BITS - 1);
            g = knee_curve(x, w) - x + longint'(w[MK_LSB +: 6]) * 8;
            m_gain[b] = clip(div_round(m_gain[b] * 3686
                             + db_to_linear(clip(g, DB_FLOOR, DB_CEIL)) * 410, 4096),
                             0, LIN_MAX);
            sum += m_gain[b];
        end
        mean = div_round(sum, n);
        r.smp = SAMPLE_BITS'(clip(div_round(smp * mean, 65536), -8388608, 8388607));
        r.mdb = MDB_W'((mean == 0) ? DB_FLOOR : clip(level_db(mean, 16), DB_FLOOR, DB_CEIL));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gain_result_t want;
        if (!rst_n)
        begin
            m_band_count = 1;
            m_key_sel = 0;
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                m_word[b] = '0;
                m_env[b] = 0;
                m_gain[b] = 65536;
            end
            expected_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (dout.valid && dout.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output transaction: out_sample %0d mean_gain_db %0d",
                                 dout.out_sample, dout.mean_gain_db);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.smp !== dout.out_sample || want.mdb !== dout.mean_gain_db)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: out_sample %0d/%0d mean_gain_db %0d/%0d (exp/act)",
                                     want.smp, dout.out_sample, want.mdb, dout.mean_gain_db);
                    end
                end
            end
            if (din.valid && din.ready)
                expected_q.push_back(compress(din.audio_sample, din.key_sample));
            if (cfg_en)
            begin
                case (cfg_addr)
                    REG_BAND_COUNT: m_band_count = cfg_data[CNT_W-1:0];
                    REG_KEY_SEL:    m_key_sel = cfg_data[0];
                    REG_BAND_WORD0: m_word[0] = cfg_data;
                    REG_BAND_WORD1: m_word[1] = cfg_data;
                    REG_BAND_WORD2: m_word[2] = cfg_data;
                    REG_BAND_WORD3: m_word[3] = cfg_data;
                    default: ;
                endcase
            end
            pending <= expected_q.size();
        end
    end

endmodule

[sim/sidechain_multiband_compressor_test.sv]
// stimulus, clock, reset and verdict for the sidechain multiband compressor
module sidechain_multiband_compressor_test;
    import smbc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 100;
    localparam int PHASE_ITEMS = 200;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     errors;
    int                     pending;
    int                     burst_left;
    int                     idle_cycles;
    int                     rx_cycle;

    smbc_in_if  in_ch ();
    smbc_out_if out_ch ();

    sidechain_multiband_compressor i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .din      (in_ch),
        .dout     (out_ch)
    );

    smbc_gain_checker i_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .din      (in_ch),
        .dout     (out_ch),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_en = 0;
        cfg_addr = '0;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.audio_sample = '0;
        in_ch.key_sample = '0;
        out_ch.ready = 0;
        burst_left = 0;
        idle_cycles = 0;
        rx_cycle = 0;
    end

    always #2 clk = ~clk;

    // receiver: changing stall patterns plus one long hold-off
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle >= 3000 && rx_cycle < 3400)
            out_ch.ready <= 1'b0;
        else
        begin
            case ((rx_cycle / 250) % 3)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sidechain_multiband_compressor_test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] audio,
                               logic signed [SAMPLE_BITS-1:0] key_in);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.audio_sample <= audio;
        in_ch.key_sample <= key_in;
        do
            @(posedge clk);
        while (!in_ch.ready);
        burst_left--;
    endtask

    // stop offering and wait until every result is back and the block is quiet
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] random_level();
        logic signed [SAMPLE_BITS-1:0] r;
        r = SAMPLE_BITS'($urandom);
        return r >>> $urandom_range(0, SAMPLE_BITS - 1);
    endfunction

    function automatic logic [63:0] random_band_word();
        logic [63:0] w;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        w = '0;
        w[THR_LSB +: 12]  = 12'(-$urandom_range(0, 1200));
        w[KNEE_LSB +: 10] = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
        w[IR_LSB +: 12]   = 12'($urandom_range(0, 4095));
        w[ATK_LSB +: 12]  = 12'($urandom_range(200, 4095));
        w[REL_LSB +: 12]  = 12'($urandom_range(20, 4095));
        w[MK_LSB +: 6]    = 6'($urandom_range(0, 63));
        return w;
    endfunction

    task automatic directed_samples();
        logic signed [SAMPLE_BITS-1:0] levels [6];
        levels = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1, 24'sh000400};
        for (int i = 0; i < 6; i++)
            send_sample(levels[i], levels[5 - i]);
        send_sample(24'sh7FFFFF, 24'sh7FFFFF);
        send_sample(-24'sh800000, -24'sh800000);
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] band_set [MAX_BANDS];
        logic [CNT_W-1:0]      counts [8];
        counts = '{3'd1, 3'd4, 3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: no envelope motion, gain state starting at unity
        directed_samples();
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            for (int b = 0; b < MAX_BANDS; b++)
            begin
                if (phase == 3)
                    band_set[b] = '1;
                else if (phase == 4)
                    band_set[b] = '0;
                else
                    band_set[b] = random_band_word();
            end
            write_reg(REG_BAND_COUNT, CFG_DATA_W'(counts[phase]));
            write_reg(REG_KEY_SEL, CFG_DATA_W'(phase % 2));
            write_reg(REG_BAND_WORD0, band_set[0]);
            write_reg(REG_BAND_WORD1, band_set[1]);
            write_reg(REG_BAND_WORD2, band_set[2]);
            write_reg(REG_BAND_WORD3, band_set[3]);
            // unused index must be ignored
            write_reg(CFG_ADDR_W'(6), '1);
            cfg_en <= 1'b0;
            @(posedge clk);
            if (phase == 0)
                directed_samples();
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(random_level(), random_level());
            drain();
        end

        if (errors == 0)
            $display("sidechain_multiband_compressor_test passed");
        else
            $display("sidechain_multiband_compressor_test failed");
        $finish;
    end

endmodule
